// File: src/rbgrk_pkg.sv
// Shared types and constants for the row bitmap Gray rank key block.
package rbgrk_pkg;

    localparam int MAX_BINS_DEF    = 64;
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int DIV_STEPS       = 32;
    localparam int KEY_WIDTH       = 64;

    localparam logic [1:0] REG_BINS_IN_USE     = 2'd0;
    localparam logic [1:0] REG_COLUMNS_PER_BIN = 2'd1;
    localparam logic [1:0] REG_DENSE_MODE      = 2'd2;

    localparam logic [6:0]  BINS_IN_USE_RST     = 7'd64;
    localparam logic [31:0] COLUMNS_PER_BIN_RST = 32'd1;
    localparam logic        DENSE_MODE_RST      = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_UPDATE,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

endpackage

// File: src/rbgrk_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rbgrk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/row_bitmap_gray_rank_key.sv
// Top level: per-bin nonzero counter that emits a Gray-decoded row bitmap key.
// Non-last item: accept, 32 shared radix-2 divider steps, read, update.
// Last item: plus a scan of the bins in use (one bin count read per cycle from the
// count RAM), a drain and an emit; dense mode adds a second pass of 32 divider steps
// for the threshold. Empty-row item: accept, then emit. Emit holds while the previous
// result waits. One transaction in flight; a new item is accepted only in idle.
// Reset (synchronous, aresetn low): registers to defaults, all bin counts read as zero.
module row_bitmap_gray_rank_key #(
    parameter int MAX_BINS    = rbgrk_pkg::MAX_BINS_DEF,
    parameter int COUNT_WIDTH = rbgrk_pkg::COUNT_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_column_index,
    input  logic        s_last_in_row,
    input  logic        s_empty_row,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_rank_key,
    output logic [31:0] m_row_nonzeros,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int BIN_W  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int BINS_W = $clog2(MAX_BINS + 1);
    localparam int STEP_W = $clog2(rbgrk_pkg::DIV_STEPS);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // configuration
    logic [6:0]  bins_in_use_reg;
    logic [31:0] columns_per_bin_reg;
    logic        dense_mode_reg;

    // control
    rbgrk_pkg::state_t state_reg, state_next;
    logic                   m_valid_reg, m_valid_next;
    logic [MAX_BINS-1:0]    valid_reg, valid_next;
    logic [COUNT_WIDTH-1:0] row_count_reg, row_count_next;
    logic [STEP_W-1:0]      step_reg, step_next;

    // datapath
    logic [31:0]            dvd_reg, dvd_next;
    logic [32:0]            rem_reg, rem_next;
    logic [31:0]            dvs_reg, dvs_next;
    logic                   div_thr_reg, div_thr_next;
    logic                   last_reg, last_next;
    logic                   empty_reg, empty_next;
    logic [BIN_W-1:0]       bin_reg, bin_next;
    logic [COUNT_WIDTH-1:0] thresh_reg, thresh_next;
    logic [BIN_W-1:0]       scan_idx_reg, scan_idx_next;
    logic                   chk_vld_reg, chk_vld_next;
    logic [BIN_W-1:0]       chk_idx_reg, chk_idx_next;
    logic                   parity_reg, parity_next;
    logic [MAX_BINS-1:0]    key_reg, key_next;
    logic [63:0]            m_key_reg, m_key_next;
    logic [31:0]            m_nnz_reg, m_nnz_next;

    // combinational helpers
    logic [BINS_W-1:0]      bins_act;
    logic [BIN_W-1:0]       bins_last;
    logic [32:0]            rem_sh;
    logic [33:0]            diff;
    logic                   ge;
    logic [COUNT_WIDTH-1:0] cnt_cur;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic [COUNT_WIDTH-1:0] row_inc;
    logic [COUNT_WIDTH-1:0] chk_cnt;
    logic                   chk_bit;
    logic                   ram_we;
    logic [BIN_W-1:0]       ram_raddr;
    logic [COUNT_WIDTH-1:0] ram_rdata;

    always_comb begin
        if (bins_in_use_reg == 7'd0) begin
            bins_act = BINS_W'(1);
        end else if (bins_in_use_reg > 7'(MAX_BINS)) begin
            bins_act = BINS_W'(MAX_BINS);
        end else begin
            bins_act = BINS_W'(bins_in_use_reg);
        end
    end

    assign bins_last = BIN_W'(bins_act - BINS_W'(1));

    // APB register file
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bins_in_use_reg     <= rbgrk_pkg::BINS_IN_USE_RST;
            columns_per_bin_reg <= rbgrk_pkg::COLUMNS_PER_BIN_RST;
            dense_mode_reg      <= rbgrk_pkg::DENSE_MODE_RST;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                rbgrk_pkg::REG_BINS_IN_USE:     bins_in_use_reg     <= pwdata[6:0];
                rbgrk_pkg::REG_COLUMNS_PER_BIN: columns_per_bin_reg <= pwdata;
                rbgrk_pkg::REG_DENSE_MODE:      dense_mode_reg      <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            rbgrk_pkg::REG_BINS_IN_USE:     prdata = {25'd0, bins_in_use_reg};
            rbgrk_pkg::REG_COLUMNS_PER_BIN: prdata = columns_per_bin_reg;
            rbgrk_pkg::REG_DENSE_MODE:      prdata = {31'd0, dense_mode_reg};
            default:                        prdata = 32'd0;
        endcase
    end

    // shared restoring divider step
    assign rem_sh = {rem_reg[31:0], dvd_reg[31]};
    assign diff   = {1'b0, rem_sh} - {2'b00, dvs_reg};
    assign ge     = ~diff[33];

    // count update and scan compare
    assign cnt_cur = valid_reg[bin_reg] ? ram_rdata : '0;
    assign cnt_inc = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + COUNT_WIDTH'(1);
    assign row_inc = (row_count_reg == COUNT_MAX) ? row_count_reg
                                                  : row_count_reg + COUNT_WIDTH'(1);
    assign chk_cnt = valid_reg[chk_idx_reg] ? ram_rdata : '0;
    assign chk_bit = chk_cnt > thresh_reg;

    always_comb begin
        state_next    = state_reg;
        m_valid_next  = m_valid_reg;
        valid_next    = valid_reg;
        row_count_next = row_count_reg;
        step_next     = step_reg;
        dvd_next      = dvd_reg;
        rem_next      = rem_reg;
        dvs_next      = dvs_reg;
        div_thr_next  = div_thr_reg;
        last_next     = last_reg;
        empty_next    = empty_reg;
        bin_next      = bin_reg;
        thresh_next   = thresh_reg;
        scan_idx_next = scan_idx_reg;
        chk_vld_next  = 1'b0;
        chk_idx_next  = chk_idx_reg;
        parity_next   = parity_reg;
        key_next      = key_reg;
        m_key_next    = m_key_reg;
        m_nnz_next    = m_nnz_reg;
        ram_we        = 1'b0;
        ram_raddr     = bin_reg;
        s_ready       = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // fold the scanned bin into the running Gray-to-binary parity
        if (chk_vld_reg) begin
            parity_next           = parity_reg ^ chk_bit;
            key_next[chk_idx_reg] = parity_reg ^ chk_bit;
        end

        unique case (state_reg)
            rbgrk_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    last_next  = s_last_in_row;
                    empty_next = s_empty_row;
                    if (s_empty_row) begin
                        key_next   = '0;
                        state_next = rbgrk_pkg::ST_EMIT;
                    end else begin
                        dvd_next     = s_column_index;
                        rem_next     = '0;
                        dvs_next     = (columns_per_bin_reg == 32'd0) ? 32'd1
                                                                      : columns_per_bin_reg;
                        step_next    = '0;
                        div_thr_next = 1'b0;
                        state_next   = rbgrk_pkg::ST_DIV;
                    end
                end
            end
            rbgrk_pkg::ST_DIV: begin
                rem_next  = ge ? diff[32:0] : rem_sh;
                dvd_next  = {dvd_reg[30:0], ge};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(rbgrk_pkg::DIV_STEPS - 1)) begin
                    if (div_thr_reg) begin
                        thresh_next   = COUNT_WIDTH'({dvd_reg[30:0], ge});
                        scan_idx_next = bins_last;
                        key_next      = '0;
                        parity_next   = 1'b0;
                        state_next    = rbgrk_pkg::ST_SCAN;
                    end else begin
                        if ({dvd_reg[30:0], ge} > 32'(bins_last)) begin
                            bin_next = bins_last;
                        end else begin
                            bin_next = BIN_W'({dvd_reg[30:0], ge});
                        end
                        state_next = rbgrk_pkg::ST_READ;
                    end
                end
            end
            rbgrk_pkg::ST_READ: begin
                ram_raddr  = bin_reg;
                state_next = rbgrk_pkg::ST_UPDATE;
            end
            rbgrk_pkg::ST_UPDATE: begin
                ram_we              = 1'b1;
                valid_next[bin_reg] = 1'b1;
                row_count_next      = row_inc;
                if (!last_reg) begin
                    state_next = rbgrk_pkg::ST_IDLE;
                end else if (dense_mode_reg) begin
                    dvd_next     = 32'(row_inc);
                    rem_next     = '0;
                    dvs_next     = 32'(bins_act);
                    step_next    = '0;
                    div_thr_next = 1'b1;
                    state_next   = rbgrk_pkg::ST_DIV;
                end else begin
                    thresh_next   = '0;
                    scan_idx_next = bins_last;
                    key_next      = '0;
                    parity_next   = 1'b0;
                    state_next    = rbgrk_pkg::ST_SCAN;
                end
            end
            rbgrk_pkg::ST_SCAN: begin
                ram_raddr    = scan_idx_reg;
                chk_vld_next = 1'b1;
                chk_idx_next = scan_idx_reg;
                if (scan_idx_reg == '0) begin
                    state_next = rbgrk_pkg::ST_DRAIN;
                end else begin
                    scan_idx_next = scan_idx_reg - BIN_W'(1);
                end
            end
            rbgrk_pkg::ST_DRAIN: begin
                state_next = rbgrk_pkg::ST_EMIT;
            end
            rbgrk_pkg::ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_key_next     = 64'(key_reg);
                    m_nnz_next     = empty_reg ? 32'd0 : 32'(row_count_reg);
                    valid_next     = '0;
                    row_count_next = '0;
                    state_next     = rbgrk_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rbgrk_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rbgrk_pkg::ST_IDLE;
            m_valid_reg   <= 1'b0;
            valid_reg     <= '0;
            row_count_reg <= '0;
            step_reg      <= '0;
            chk_vld_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            valid_reg     <= valid_next;
            row_count_reg <= row_count_next;
            step_reg      <= step_next;
            chk_vld_reg   <= chk_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        dvs_reg      <= dvs_next;
        div_thr_reg  <= div_thr_next;
        last_reg     <= last_next;
        empty_reg    <= empty_next;
        bin_reg      <= bin_next;
        thresh_reg   <= thresh_next;
        scan_idx_reg <= scan_idx_next;
        chk_idx_reg  <= chk_idx_next;
        parity_reg   <= parity_next;
        key_reg      <= key_next;
        m_key_reg    <= m_key_next;
        m_nnz_reg    <= m_nnz_next;
    end

    rbgrk_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (MAX_BINS),
        .ADDR_W(BIN_W)
    ) u_count_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(bin_reg),
        .wdata(cnt_inc),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign m_valid        = m_valid_reg;
    assign m_rank_key     = m_key_reg;
    assign m_row_nonzeros = m_nnz_reg;

endmodule
